// File: rtl/core/ubod_pkg.sv
// Shared constants and types for the UYVY byte-offset detector.
// No dependencies; every other file of the block imports this package.
package ubod_pkg;

  // Fixed field widths
  localparam int BYTE_W       = 8;
  localparam int LINE_LEN_W   = 13;
  localparam int FRAME_ROWS_W = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;

  // Register reset values and lower limits
  localparam int RB_RESET = 1440;
  localparam int FR_RESET = 240;
  localparam int RB_MIN   = 4;
  localparam int FR_MIN   = 3;

  // Neutral chroma level
  localparam logic [BYTE_W-1:0] MID_LEVEL = 8'd128;

  // x/3 == (x * DIV3_MUL) >> DIV3_SHIFT, exact for x below 32768
  localparam int DIV3_MUL   = 21846;
  localparam int DIV3_SHIFT = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_LEN   = 2'd0,
    REG_FRAME_ROWS = 2'd1
  } cfg_reg_t;

  // Frame tracker status
  typedef struct packed {
    logic frame_active;  // a frame is in progress
    logic frame_end;     // this transfer closes the frame
  } acc_status_t;

endpackage

// File: rtl/core/ubod_if.sv
// Channel interfaces of the UYVY byte-offset detector: input bytes,
// results and configuration writes. Depends on ubod_pkg.

interface ubod_in_if import ubod_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              frame_start;

  modport source (output valid, data_byte, frame_start, input ready);
  modport sink   (input valid, data_byte, frame_start, output ready);
endinterface

interface ubod_out_if import ubod_pkg::*; ();
  logic valid;
  logic ready;
  logic shift_needed;
  logic chroma_vote;

  modport source (output valid, shift_needed, chroma_vote, input ready);
  modport sink   (input valid, shift_needed, chroma_vote, output ready);
endinterface

interface ubod_cfg_if import ubod_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/ubod_accum.sv
// Frame tracker and per-parity accumulators of the byte-offset detector.
// Depends on ubod_pkg.
module ubod_accum import ubod_pkg::*; #(
  parameter int MAX_ROW_BYTES = 4096,
  parameter int MAX_ROWS      = 1024,
  localparam int BIR_W = $clog2(MAX_ROW_BYTES),
  localparam int RB_W  = $clog2(MAX_ROW_BYTES + 1),
  localparam int ROW_W = $clog2(MAX_ROWS),
  localparam int CNT_W = $clog2(MAX_ROW_BYTES + 2),
  localparam int SUM_W = BYTE_W + CNT_W,
  localparam int SQ_W  = 2 * BYTE_W + CNT_W,
  localparam int DEV_W = BYTE_W + CNT_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              frame_start,
  input  logic [RB_W-1:0]   rb,
  input  logic [ROW_W-1:0]  row_a,
  input  logic [ROW_W-1:0]  row_b,
  output acc_status_t       status,
  output logic [SUM_W-1:0]  e_sum,
  output logic [SUM_W-1:0]  o_sum,
  output logic [SQ_W-1:0]   e_sq,
  output logic [SQ_W-1:0]   o_sq,
  output logic [DEV_W-1:0]  e_dev,
  output logic [DEV_W-1:0]  o_dev
);

  logic [BIR_W-1:0] bir_r, bir_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             done_r, done_nxt;
  logic [SUM_W-1:0] e_sum_r, o_sum_r, e_sum_nxt, o_sum_nxt;
  logic [SQ_W-1:0]  e_sq_r, o_sq_r, e_sq_nxt, o_sq_nxt;
  logic [DEV_W-1:0] e_dev_r, o_dev_r, e_dev_nxt, o_dev_nxt;

  logic [BIR_W-1:0]    cur_bir;
  logic [ROW_W-1:0]    cur_row;
  logic                cur_done;
  logic [RB_W-1:0]     n4;
  logic [BYTE_W-1:0]   dev;
  logic [2*BYTE_W-1:0] sq;
  logic                sampled;
  logic                in_dev;
  logic                row_end;
  logic                last_row;

  // Byte-level terms
  assign n4  = {rb[RB_W-1:2], 2'b00};
  assign dev = (data_byte >= MID_LEVEL) ? (data_byte - MID_LEVEL) : (MID_LEVEL - data_byte);
  assign sq  = (2*BYTE_W)'(data_byte) * (2*BYTE_W)'(data_byte);

  // A start byte sees cleared state
  assign cur_bir  = frame_start ? '0 : bir_r;
  assign cur_row  = frame_start ? '0 : row_r;
  assign cur_done = frame_start ? 1'b0 : done_r;

  assign sampled  = (cur_row == row_a) || (cur_row == row_b);
  assign in_dev   = RB_W'(cur_bir) < n4;
  assign row_end  = ((RB_W+1)'(cur_bir) + (RB_W+1)'(1)) >= (RB_W+1)'(rb);
  assign last_row = cur_row >= row_b;

  // Next state of counters and accumulators
  always_comb begin
    bir_nxt   = cur_bir;
    row_nxt   = cur_row;
    done_nxt  = cur_done;
    e_sum_nxt = frame_start ? '0 : e_sum_r;
    o_sum_nxt = frame_start ? '0 : o_sum_r;
    e_sq_nxt  = frame_start ? '0 : e_sq_r;
    o_sq_nxt  = frame_start ? '0 : o_sq_r;
    e_dev_nxt = frame_start ? '0 : e_dev_r;
    o_dev_nxt = frame_start ? '0 : o_dev_r;
    if (!cur_done) begin
      if (sampled) begin
        if (cur_bir[0]) begin
          o_sum_nxt = o_sum_nxt + SUM_W'(data_byte);
          o_sq_nxt  = o_sq_nxt + SQ_W'(sq);
          if (in_dev) o_dev_nxt = o_dev_nxt + DEV_W'(dev);
        end else begin
          e_sum_nxt = e_sum_nxt + SUM_W'(data_byte);
          e_sq_nxt  = e_sq_nxt + SQ_W'(sq);
          if (in_dev) e_dev_nxt = e_dev_nxt + DEV_W'(dev);
        end
      end
      if (row_end) begin
        bir_nxt = '0;
        if (last_row) done_nxt = 1'b1;
        else          row_nxt  = cur_row + ROW_W'(1);
      end else begin
        bir_nxt = cur_bir + BIR_W'(1);
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bir_r  <= '0;
      row_r  <= '0;
      done_r <= 1'b1;
    end else if (in_fire) begin
      bir_r  <= bir_nxt;
      row_r  <= row_nxt;
      done_r <= done_nxt;
    end
  end

  // Accumulators, cleared by the start byte
  always_ff @(posedge clk) begin
    if (in_fire) begin
      e_sum_r <= e_sum_nxt;
      o_sum_r <= o_sum_nxt;
      e_sq_r  <= e_sq_nxt;
      o_sq_r  <= o_sq_nxt;
      e_dev_r <= e_dev_nxt;
      o_dev_r <= o_dev_nxt;
    end
  end

  assign status.frame_active = !done_r;
  assign status.frame_end    = in_fire && !cur_done && row_end && last_row;

  // Final sums including the closing byte
  assign e_sum = e_sum_nxt;
  assign o_sum = o_sum_nxt;
  assign e_sq  = e_sq_nxt;
  assign o_sq  = o_sq_nxt;
  assign e_dev = e_dev_nxt;
  assign o_dev = o_dev_nxt;

endmodule

// File: rtl/core/ubod_vote.sv
// Variance and chroma vote pipeline: snapshot, products, differences,
// result register, each stage elastic. Depends on ubod_pkg.
module ubod_vote import ubod_pkg::*; #(
  parameter int MAX_ROW_BYTES = 4096,
  localparam int RB_W   = $clog2(MAX_ROW_BYTES + 1),
  localparam int CNT_W  = $clog2(MAX_ROW_BYTES + 2),
  localparam int SUM_W  = BYTE_W + CNT_W,
  localparam int SQ_W   = 2 * BYTE_W + CNT_W,
  localparam int DEV_W  = BYTE_W + CNT_W,
  localparam int P_W    = SQ_W + RB_W,
  localparam int Q_W    = 2 * SUM_W,
  localparam int PROD_W = (P_W > Q_W) ? P_W : Q_W,
  localparam int VAR_W  = PROD_W + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             snap_valid,
  output logic             snap_ready,
  input  logic [SUM_W-1:0] e_sum,
  input  logic [SUM_W-1:0] o_sum,
  input  logic [SQ_W-1:0]  e_sq,
  input  logic [SQ_W-1:0]  o_sq,
  input  logic [DEV_W-1:0] e_dev,
  input  logic [DEV_W-1:0] o_dev,
  input  logic [RB_W-1:0]  rb,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             shift_needed,
  output logic             chroma_vote
);

  logic v1_r, v2_r, v3_r, vo_r;
  logic rdy1, rdy2, rdy3, rdy_o;

  logic [SUM_W-1:0] e_sum1_r, o_sum1_r;
  logic [SQ_W-1:0]  e_sq1_r, o_sq1_r;
  logic [DEV_W-1:0] e_dev1_r, o_dev1_r;
  logic [RB_W-1:0]  rb1_r;

  logic [P_W-1:0]   e_p2_r, o_p2_r;
  logic [Q_W-1:0]   e_q2_r, o_q2_r;
  logic             chroma2_r;

  logic signed [VAR_W-1:0] var_e3_r, var_o3_r;
  logic                    chroma3_r;

  logic shift_r, chroma_r;

  logic [P_W-1:0]          e_p_nxt, o_p_nxt;
  logic [Q_W-1:0]          e_q_nxt, o_q_nxt;
  logic signed [VAR_W-1:0] var_e_nxt, var_o_nxt;

  // Stage readiness, back from the result register
  assign rdy_o      = !vo_r || out_ready;
  assign rdy3       = !v3_r || rdy_o;
  assign rdy2       = !v2_r || rdy3;
  assign rdy1       = !v1_r || rdy2;
  assign snap_ready = rdy1;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1)  v1_r <= snap_valid;
      if (rdy2)  v2_r <= v1_r;
      if (rdy3)  v3_r <= v2_r;
      if (rdy_o) vo_r <= v3_r;
    end
  end

  // Snapshot of the frame sums
  always_ff @(posedge clk) begin
    if (snap_valid && rdy1) begin
      e_sum1_r <= e_sum;
      o_sum1_r <= o_sum;
      e_sq1_r  <= e_sq;
      o_sq1_r  <= o_sq;
      e_dev1_r <= e_dev;
      o_dev1_r <= o_dev;
      rb1_r    <= rb;
    end
  end

  // Products: square sum times count, sum squared
  assign e_p_nxt = P_W'(e_sq1_r) * P_W'(rb1_r);
  assign o_p_nxt = P_W'(o_sq1_r) * P_W'(rb1_r);
  assign e_q_nxt = Q_W'(e_sum1_r) * Q_W'(e_sum1_r);
  assign o_q_nxt = Q_W'(o_sum1_r) * Q_W'(o_sum1_r);

  always_ff @(posedge clk) begin
    if (v1_r && rdy2) begin
      e_p2_r    <= e_p_nxt;
      o_p2_r    <= o_p_nxt;
      e_q2_r    <= e_q_nxt;
      o_q2_r    <= o_q_nxt;
      chroma2_r <= o_dev1_r < e_dev1_r;
    end
  end

  // Variance terms, may go negative
  assign var_e_nxt = $signed({1'b0, PROD_W'(e_p2_r)}) - $signed({1'b0, PROD_W'(e_q2_r)});
  assign var_o_nxt = $signed({1'b0, PROD_W'(o_p2_r)}) - $signed({1'b0, PROD_W'(o_q2_r)});

  always_ff @(posedge clk) begin
    if (v2_r && rdy3) begin
      var_e3_r  <= var_e_nxt;
      var_o3_r  <= var_o_nxt;
      chroma3_r <= chroma2_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (v3_r && rdy_o) begin
      shift_r  <= var_e3_r > var_o3_r;
      chroma_r <= chroma3_r;
    end
  end

  assign out_valid    = vo_r;
  assign shift_needed = shift_r;
  assign chroma_vote  = chroma_r;

endmodule

// File: rtl/core/uyvy_byte_offset_detector.sv
// UYVY byte-offset detector, top level: configuration registers, frame
// tracker and vote pipeline. Depends on ubod_pkg, ubod_if, ubod_accum, ubod_vote.
//
// Usage:
//   in_ch carries one frame byte per transfer; frame_start marks a frame's
//   first byte. Bytes outside a frame are taken and dropped. Two rows,
//   frame_rows/3 and 2*frame_rows/3, feed the even/odd statistics.
//   out_ch gives one result per frame (shift_needed, chroma_vote).
//   cfg_ch writes the row length in bytes (index 0) or frame_rows (index 1);
//   it is always ready, other indexes are dropped. Write it only while idle.
// Timing:
//   One byte per cycle sustained while in_ch.ready is high. out_ch.valid
//   rises once the transfer of the last byte of the second sampled row has
//   passed the snapshot, multiply, subtract and compare stages, each one register.
//   A stalled receiver fills the result stages one by one; in_ch.ready drops
//   only once the snapshot stage is held as well, and rises as soon as it
//   drains.
// Reset:
//   rst_n low for one cycle sets row length 1440, frame_rows 240, no frame in
//   progress and an empty result pipeline.
module uyvy_byte_offset_detector import ubod_pkg::*; #(
  parameter int MAX_ROW_BYTES = 4096,
  parameter int MAX_ROWS      = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  ubod_in_if.sink       in_ch,
  ubod_out_if.source    out_ch,
  ubod_cfg_if.sink      cfg_ch
);

  localparam int RB_W  = $clog2(MAX_ROW_BYTES + 1);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int CNT_W = $clog2(MAX_ROW_BYTES + 2);
  localparam int SUM_W = BYTE_W + CNT_W;
  localparam int SQ_W  = 2 * BYTE_W + CNT_W;
  localparam int DEV_W = BYTE_W + CNT_W;
  localparam int DIV_W = FRAME_ROWS_W + 1 + DIV3_SHIFT;

  localparam int RB_RST   = (RB_RESET > MAX_ROW_BYTES) ? MAX_ROW_BYTES : RB_RESET;
  localparam int FR_RST   = (FR_RESET > MAX_ROWS) ? MAX_ROWS : FR_RESET;
  localparam int ROWA_RST = FR_RST / 3;
  localparam int ROWB_RST = (2 * FR_RST) / 3;

  logic [RB_W-1:0]  rb_r;
  logic [ROW_W-1:0] row_a_r, row_b_r;

  logic [31:0]             rb_cfg, fr_cfg, rb_clamp, fr_clamp;
  logic [FRAME_ROWS_W-1:0] fr_eff;
  logic [DIV_W-1:0]        prod_a, prod_b;

  logic             in_fire;
  logic             snap_ready;
  acc_status_t      acc_status;
  logic [SUM_W-1:0] e_sum, o_sum;
  logic [SQ_W-1:0]  e_sq, o_sq;
  logic [DEV_W-1:0] e_dev, o_dev;

  // Configuration: clamp on write, precompute the sampled rows
  assign cfg_ch.ready = 1'b1;
  assign rb_cfg   = 32'(cfg_ch.data[LINE_LEN_W-1:0]);
  assign fr_cfg   = 32'(cfg_ch.data[FRAME_ROWS_W-1:0]);
  assign rb_clamp = (rb_cfg < 32'(RB_MIN)) ? 32'(RB_MIN) :
                    (rb_cfg > 32'(MAX_ROW_BYTES)) ? 32'(MAX_ROW_BYTES) : rb_cfg;
  assign fr_clamp = (fr_cfg < 32'(FR_MIN)) ? 32'(FR_MIN) :
                    (fr_cfg > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : fr_cfg;
  assign fr_eff   = FRAME_ROWS_W'(fr_clamp);
  assign prod_a   = DIV_W'(fr_eff) * DIV_W'(DIV3_MUL);
  assign prod_b   = DIV_W'({fr_eff, 1'b0}) * DIV_W'(DIV3_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_r    <= RB_W'(RB_RST);
      row_a_r <= ROW_W'(ROWA_RST);
      row_b_r <= ROW_W'(ROWB_RST);
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_LINE_LEN: begin
          rb_r <= RB_W'(rb_clamp);
        end
        REG_FRAME_ROWS: begin
          row_a_r <= ROW_W'(prod_a >> DIV3_SHIFT);
          row_b_r <= ROW_W'(prod_b >> DIV3_SHIFT);
        end
        default: begin
        end
      endcase
    end
  end

  // Input transfer
  assign in_ch.ready = snap_ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  ubod_accum #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .MAX_ROWS      (MAX_ROWS)
  ) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .data_byte   (in_ch.data_byte),
    .frame_start (in_ch.frame_start),
    .rb          (rb_r),
    .row_a       (row_a_r),
    .row_b       (row_b_r),
    .status      (acc_status),
    .e_sum       (e_sum),
    .o_sum       (o_sum),
    .e_sq        (e_sq),
    .o_sq        (o_sq),
    .e_dev       (e_dev),
    .o_dev       (o_dev)
  );

  ubod_vote #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_vote (
    .clk          (clk),
    .rst_n        (rst_n),
    .snap_valid   (acc_status.frame_end),
    .snap_ready   (snap_ready),
    .e_sum        (e_sum),
    .o_sum        (o_sum),
    .e_sq         (e_sq),
    .o_sq         (o_sq),
    .e_dev        (e_dev),
    .o_dev        (o_dev),
    .rb           (rb_r),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .shift_needed (out_ch.shift_needed),
    .chroma_vote  (out_ch.chroma_vote)
  );

`ifndef SYNTH
  // Bytes outside a frame never close one
  a_idle_no_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_ch.frame_start && !acc_status.frame_active) |-> !acc_status.frame_end)
    else $error("frame end without a frame in progress");

  // After the closing byte the tracker waits for the next start
  a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc_status.frame_end |=> !acc_status.frame_active)
    else $error("frame still active after its result");

  // A start byte opens a frame; it can never close it at once
  a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.frame_start) |=> acc_status.frame_active)
    else $error("start byte did not open a frame");
`endif

endmodule
